// ===== hw/rtl/qdec_pkg.sv =====
// Shared types, constants and the quadrature transition table of the encoder decoder.
package qdec_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned COUNT_W  = 32;
   localparam int unsigned STEP_W   = 9;
   localparam int unsigned FAST_W   = 8;
   localparam int unsigned ACC_W    = 4;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 32;

   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 48;

   // Two entries keep ready high while the unstalled back end pops one item a cycle.
   localparam int unsigned Q_DEPTH = 2;
   localparam int unsigned Q_PTR_W = 1;
   localparam int unsigned Q_CNT_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PAUSE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FAST_STEP = 2'd2;

   localparam logic [TIME_W-1:0] DEBOUNCE_RESET  = 32'd200;
   localparam logic [TIME_W-1:0] PAUSE_RESET     = 32'd500;
   localparam logic [FAST_W-1:0] FAST_STEP_RESET = 8'd10;

   localparam logic [1:0] AB_RESET = 2'b11;

   localparam logic signed [ACC_W-1:0] ACC_HI = 4'sd3;
   localparam logic signed [ACC_W-1:0] ACC_LO = -4'sd3;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_CLEAR  = 1'b1
   } qdec_kind_type;

   typedef struct packed {
      qdec_kind_type     kind;
      logic [1:0]        ab;       // A in bit 1, B in bit 0
      logic [TIME_W-1:0] time_us;
   } qdec_item_type;

   typedef struct packed {
      logic [TIME_W-1:0] debounce_us;
      logic [TIME_W-1:0] pause_us;
      logic [FAST_W-1:0] fast_step;
   } qdec_cfg_type;

   // Index is previous AB in the high bits and new AB in the low bits.
   function automatic logic signed [1:0] quad_value(input logic [3:0] idx);
      logic signed [1:0] val;
      case (idx)
         4'h1, 4'h7, 4'h8, 4'he: val = -2'sd1;
         4'h2, 4'h4, 4'hb, 4'hd: val = 2'sd1;
         default:                val = 2'sd0;
      endcase
      return val;
   endfunction

endpackage

// ===== hw/rtl/qdec_front.sv =====
// Front end: accepts request transfers, classifies them and queues them for the back end.
module qdec_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [qdec_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   output logic                                q_valid,
   output qdec_pkg::qdec_item_type             q_item,
   input  logic                                q_pop
);
   import qdec_pkg::*;

   qdec_item_type        entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                 push;
   qdec_item_type        item;

   assign req_tready = (cnt_ff != Q_CNT_W'(Q_DEPTH));
   assign push       = req_tvalid && req_tready;

   always_comb begin
      item.kind    = qdec_kind_type'(req_tuser);
      item.ab      = {req_tdata[0], req_tdata[1]};
      item.time_us = req_tdata[TIME_W+1:2];
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !q_pop) begin
         cnt_in = cnt_ff + Q_CNT_W'(1);
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

   assign q_valid = (cnt_ff != '0);
   assign q_item  = entry_ff[rd_ptr_ff];

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("queue fill count exceeds depth");

endmodule

// ===== hw/rtl/qdec_back.sv =====
// Back end: debounce check, transition decode, detent accumulation and the position counter.
module qdec_back (
   input  logic                                clock,
   input  logic                                reset,
   input  qdec_pkg::qdec_cfg_type              cfg,
   input  logic                                q_valid,
   input  qdec_pkg::qdec_item_type             q_item,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [qdec_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import qdec_pkg::*;

   logic [1:0]               prev_ab_ff, prev_ab_in;
   logic signed [ACC_W-1:0]  accum_ff, accum_in;
   logic [TIME_W-1:0]        last_accept_ff, last_accept_in;
   logic [TIME_W-1:0]        last_up_ff, last_up_in;
   logic [TIME_W-1:0]        last_down_ff, last_down_in;
   logic [COUNT_W-1:0]       position_ff, position_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic signed [STEP_W-1:0] rsp_step_ff;
   logic                     rsp_acc_ff;

   logic [TIME_W-1:0]        gap_accept, gap_up, gap_down;
   logic                     pass, go_up, go_down, fast;
   logic signed [ACC_W-1:0]  acc_sum;
   logic [FAST_W-1:0]        mag;
   logic signed [STEP_W-1:0] step;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      gap_accept = q_item.time_us - last_accept_ff;
      gap_up     = q_item.time_us - last_up_ff;
      gap_down   = q_item.time_us - last_down_ff;
      pass       = (q_item.kind == KIND_SAMPLE) && (gap_accept > cfg.debounce_us);
      acc_sum    = accum_ff + ACC_W'(quad_value({prev_ab_ff, q_item.ab}));
      go_up      = pass && (acc_sum > ACC_HI);
      go_down    = pass && !go_up && (acc_sum < ACC_LO);
      fast       = go_up ? (gap_up < cfg.pause_us) : (gap_down < cfg.pause_us);
      mag        = fast ? cfg.fast_step : FAST_W'(1);
      if (go_up) begin
         step = $signed({1'b0, mag});
      end else if (go_down) begin
         step = -$signed({1'b0, mag});
      end else begin
         step = '0;
      end
   end

   always_comb begin
      prev_ab_in     = prev_ab_ff;
      accum_in       = accum_ff;
      last_accept_in = last_accept_ff;
      last_up_in     = last_up_ff;
      last_down_in   = last_down_ff;
      position_in    = position_ff;
      if (q_pop) begin
         if (q_item.kind == KIND_CLEAR) begin
            position_in = '0;
         end else if (pass) begin
            prev_ab_in     = q_item.ab;
            last_accept_in = q_item.time_us;
            accum_in       = (go_up || go_down) ? '0 : acc_sum;
            position_in    = position_ff + {{(COUNT_W-STEP_W){step[STEP_W-1]}}, step};
            if (go_up) begin
               last_up_in = q_item.time_us;
            end
            if (go_down) begin
               last_down_in = q_item.time_us;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ab_ff     <= AB_RESET;
         accum_ff       <= '0;
         last_accept_ff <= '0;
         last_up_ff     <= '0;
         last_down_ff   <= '0;
         position_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         prev_ab_ff     <= prev_ab_in;
         accum_ff       <= accum_in;
         last_accept_ff <= last_accept_in;
         last_up_ff     <= last_up_in;
         last_down_ff   <= last_down_in;
         position_ff    <= position_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_count_ff <= position_in;
         rsp_step_ff  <= step;
         rsp_acc_ff   <= pass;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-COUNT_W-STEP_W-1){1'b0}}, rsp_acc_ff, rsp_step_ff,
                        rsp_count_ff};

   a_accum_range: assert property (@(posedge clock) disable iff (reset)
      (accum_ff >= ACC_LO) && (accum_ff <= ACC_HI))
      else $error("detent accumulator left its range");

   a_step_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_step_ff != '0) |-> rsp_acc_ff)
      else $error("step reported for a sample that was not accepted");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      q_pop && (q_item.kind == KIND_CLEAR) |=> (rsp_count_ff == '0) && !rsp_acc_ff)
      else $error("clear command did not report a zero count");

endmodule

// ===== hw/rtl/quadrature_decoder_accel_top.sv =====
// Top level of the quadrature encoder decoder: settings registers, front and back ends.
//
// Requests arrive on the req_ channel, one transfer per pin-change sample or counter
// clear (req_tuser high). Every request produces exactly one response on the rsp_
// channel carrying the position count after that request, the step applied and
// whether the sample passed the debounce interval.
// A request taken is registered in the queue and then in the output register before
// it is offered as a response. Throughput is one request per cycle while the receiver
// does not stall; the whole state update (debounce subtract and compare, table lookup,
// detent add, pause compare and counter add) is done combinationally in the back end.
// A two-entry queue separates the front and the back end, and the response sits in
// an output register. When the receiver stalls, the output register holds its value,
// the queue fills and req_tready drops once both entries are taken.
// Settings are written through csr_ at any edge with csr_we high; writes to index
// three are ignored. Write them only while no request is in flight.
// Synchronous reset restores the default settings (debounce 200, pause 500, fast step
// 10), sets the previous AB pair to both high, clears the counter, the timestamps and
// the detent accumulator, and empties the queue and the output register.
module quadrature_decoder_accel_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // a_level [0], b_level [1], time_us [33:2], zero fill [39:34]
   input  logic [qdec_pkg::REQ_DATA_W-1:0]      req_tdata,
   // kind [0]
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // count [31:0], step_applied [40:32], accepted [41], zero fill [47:42]
   output logic [qdec_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_we,
   input  logic [qdec_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  logic [qdec_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import qdec_pkg::*;

   qdec_cfg_type  cfg_ff, cfg_in;
   logic          q_valid;
   logic          q_pop;
   qdec_item_type q_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_DEBOUNCE:  cfg_in.debounce_us = csr_wdata;
            REG_PAUSE:     cfg_in.pause_us    = csr_wdata;
            REG_FAST_STEP: cfg_in.fast_step   = csr_wdata[FAST_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_us <= DEBOUNCE_RESET;
         cfg_ff.pause_us    <= PAUSE_RESET;
         cfg_ff.fast_step   <= FAST_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   qdec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   qdec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the quadrature decoder: directed turns, setting extremes, random rotation.
module tb;
   import qdec_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef enum bit {
      TURN_UP,
      TURN_DOWN
   } turn_dir_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [STEP_W-1:0]  step;
      logic               accepted;
   } position_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Decoder state as the testbench expects it to be after every accepted request.
   logic [1:0]         enc_prev_ab;
   int                 enc_detent;
   logic [TIME_W-1:0]  enc_last_accept;
   logic [TIME_W-1:0]  enc_last_up;
   logic [TIME_W-1:0]  enc_last_down;
   logic [COUNT_W-1:0] enc_position;
   logic [TIME_W-1:0]  cfg_debounce;
   logic [TIME_W-1:0]  cfg_pause;
   logic [FAST_W-1:0]  cfg_fast_step;

   position_result_type expected_positions[$];
   logic [TIME_W-1:0]   sim_us;
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int mismatches = 0;
   int n_items = 0;
   int n_accepted = 0;
   int n_clears = 0;
   int n_detents = 0;
   int n_fast = 0;
   int n_settings = 0;

   quadrature_decoder_accel_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Next pin state when the shaft turns one quarter step in the given direction.
   function automatic logic [1:0] next_ab(input logic [1:0] ab, input turn_dir_type dir);
      logic [1:0] nxt;
      if (dir == TURN_UP) begin
         case (ab)
            2'b11:   nxt = 2'b01;
            2'b01:   nxt = 2'b00;
            2'b00:   nxt = 2'b10;
            default: nxt = 2'b11;
         endcase
      end else begin
         case (ab)
            2'b11:   nxt = 2'b10;
            2'b10:   nxt = 2'b00;
            2'b00:   nxt = 2'b01;
            default: nxt = 2'b11;
         endcase
      end
      return nxt;
   endfunction

   function automatic position_result_type predict_position(input qdec_kind_type kind,
         input logic [1:0] ab, input logic [TIME_W-1:0] t);
      position_result_type res;
      logic [TIME_W-1:0]   since_accept;
      logic [TIME_W-1:0]   since_turn;
      logic [TIME_W-1:0]   mag;
      logic [TIME_W-1:0]   step;
      res = '0;
      step = '0;
      since_accept = t - enc_last_accept;
      n_items++;
      if (kind == KIND_CLEAR) begin
         enc_position = '0;
         n_clears++;
      end else if (since_accept > cfg_debounce) begin
         res.accepted = 1'b1;
         n_accepted++;
         // A single quarter step moves the detent sum; no change or a double jump does not.
         if (ab == next_ab(enc_prev_ab, TURN_UP)) begin
            enc_detent++;
         end else if (ab == next_ab(enc_prev_ab, TURN_DOWN)) begin
            enc_detent--;
         end
         enc_prev_ab = ab;
         if (enc_detent > int'(ACC_HI) || enc_detent < int'(ACC_LO)) begin
            since_turn = t - ((enc_detent > int'(ACC_HI)) ? enc_last_up : enc_last_down);
            mag = 1;
            if (since_turn < cfg_pause) begin
               mag = TIME_W'(cfg_fast_step);
               n_fast++;
            end
            if (enc_detent > int'(ACC_HI)) begin
               step = mag;
               enc_last_up = t;
            end else begin
               step = -mag;
               enc_last_down = t;
            end
            enc_position += step;
            enc_detent = 0;
            n_detents++;
         end
         enc_last_accept = t;
      end
      res.count = enc_position;
      res.step = step[STEP_W-1:0];
      return res;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap(input int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(4) != 0) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   // Time between samples: some inside the debounce window, most just past it.
   function automatic logic [TIME_W-1:0] pick_delta();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) return $urandom_range(cfg_debounce);
      if (roll < 70) return cfg_debounce + 1 + $urandom_range(63);
      if (roll < 95) return cfg_debounce + 1 + $urandom_range(4000);
      return $urandom;
   endfunction

   task automatic send_item(input qdec_kind_type kind, input logic [1:0] ab,
         input logic [TIME_W-1:0] t);
      int gap;
      gap = pick_gap(req_gap_pct);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DATA_W-TIME_W-2){1'b0}}, t, ab[0], ab[1]};
      do @(posedge clock); while (!req_tready);
      expected_positions.push_back(predict_position(kind, ab, t));
   endtask

   task automatic send_sample(input logic [1:0] ab, input logic [TIME_W-1:0] delta);
      sim_us += delta;
      send_item(KIND_SAMPLE, ab, sim_us);
   endtask

   // Stops the request stream and waits until every response has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_positions.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic apply_settings(input logic [TIME_W-1:0] debounce, input logic [TIME_W-1:0] pause,
         input logic [FAST_W-1:0] fast);
      drain();
      write_reg(REG_DEBOUNCE, debounce);
      write_reg(REG_PAUSE, pause);
      write_reg(REG_FAST_STEP, {{(CSR_DATA_W-FAST_W){1'b0}}, fast});
      cfg_debounce  = debounce;
      cfg_pause     = pause;
      cfg_fast_step = fast;
      n_settings++;
   endtask

   task automatic run_rotation(input int n_samples);
      int unsigned  roll;
      turn_dir_type dir;
      dir = turn_dir_type'($urandom_range(1));
      repeat (n_samples) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            send_item(KIND_CLEAR, 2'($urandom), $urandom);
         end else if (roll < 15) begin
            send_sample(2'($urandom), pick_delta());
         end else begin
            // Mostly clean detents; an occasional reversal breaks one halfway.
            if ($urandom_range(15) == 0) dir = (dir == TURN_UP) ? TURN_DOWN : TURN_UP;
            send_sample(next_ab(enc_prev_ab, dir), pick_delta());
         end
      end
   endtask

   task automatic test_directed_turns();
      sim_us = '0;
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      // Right after reset no time has passed since the last accepted sample.
      send_sample(2'b11, 0);
      send_sample(2'b01, 200);
      send_sample(2'b01, 1);
      send_sample(2'b00, 201);
      send_sample(2'b10, 201);
      send_sample(2'b11, 201);
      send_sample(2'b10, 201);
      send_sample(2'b00, 201);
      send_sample(2'b01, 201);
      send_sample(2'b11, 201);
      // Both pins flip at once, which cannot be decoded, then flip back.
      send_sample(2'b00, 201);
      send_sample(2'b11, 201);
      send_item(KIND_CLEAR, 2'b00, '0);
      // Contact bounce: a quarter step forward and straight back.
      send_sample(2'b01, 201);
      send_sample(2'b11, 201);
      // Timestamps at the top of the range and across the wrap.
      sim_us = 32'hFFFF_FF00;
      send_sample(2'b01, 0);
      send_sample(2'b00, 32'hFF);
      send_sample(2'b10, 201);
      send_sample(2'b11, 201);
      send_item(KIND_CLEAR, 2'b11, '1);
   endtask

   task automatic test_setting_extremes();
      req_gap_pct = 20;
      rsp_stall_pct = 20;
      apply_settings('0, '1, 8'hFF);
      run_rotation(30);
      apply_settings('1, '0, 8'd1);
      run_rotation(20);
      apply_settings('0, '0, 8'd1);
      run_rotation(30);
      // A fast detent with a zero step still restarts the detent sum.
      apply_settings(32'd10, '1, 8'd0);
      run_rotation(30);
      // A write to the unused index must leave the settings alone.
      drain();
      write_reg(REG_UNUSED, $urandom);
      run_rotation(20);
   endtask

   task automatic test_random_rotation();
      for (int phase = 0; phase < 5; phase++) begin
         req_gap_pct = (phase == 0) ? 0 : $urandom_range(50);
         rsp_stall_pct = (phase == 0) ? 0 : $urandom_range(50);
         apply_settings($urandom_range(300), $urandom_range(4000), 8'($urandom_range(255, 1)));
         if ($urandom_range(1) != 0) sim_us = $urandom;
         run_rotation(160);
      end
   endtask

   initial begin : rsp_stalls
      int hold;
      hold = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) hold--;
         else hold = pick_gap(rsp_stall_pct);
         rsp_tready <= (hold == 0);
      end
   end

   always @(posedge clock) begin : check_positions
      position_result_type want;
      position_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.count    = rsp_tdata[COUNT_W-1:0];
         got.step     = rsp_tdata[COUNT_W +: STEP_W];
         got.accepted = rsp_tdata[COUNT_W+STEP_W];
         if (expected_positions.size() == 0) begin
            $display("%0t: response transfer with none expected, actual count %0d", $time,
                     $signed(got.count));
            mismatches++;
         end else begin
            want = expected_positions.pop_front();
            if (got.count !== want.count) begin
               $display("%0t: count expected %0d, actual %0d", $time, $signed(want.count),
                        $signed(got.count));
               mismatches++;
            end
            if (got.step !== want.step) begin
               $display("%0t: step_applied expected %0d, actual %0d", $time, $signed(want.step),
                        $signed(got.step));
               mismatches++;
            end
            if (got.accepted !== want.accepted) begin
               $display("%0t: accepted expected %0b, actual %0b", $time, want.accepted,
                        got.accepted);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: no transfer for %0d cycles, %0d responses outstanding", $time, STALL_LIMIT,
               expected_positions.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      enc_prev_ab     = AB_RESET;
      enc_detent      = 0;
      enc_last_accept = '0;
      enc_last_up     = '0;
      enc_last_down   = '0;
      enc_position    = '0;
      cfg_debounce    = DEBOUNCE_RESET;
      cfg_pause       = PAUSE_RESET;
      cfg_fast_step   = FAST_STEP_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_turns();
      test_setting_extremes();
      test_random_rotation();
      drain();
      $display("Ran %0d requests under %0d settings: %0d samples accepted, %0d counter clears.",
               n_items, n_settings, n_accepted, n_clears);
      $display("%0d detents counted, %0d at the fast rate; %0d mismatches.", n_detents, n_fast,
               mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
